FILE: hw/rtl/tvbd_pkg.sv
// Shared types and constants for the block decipher core.
// No dependencies.
package tvbd_pkg;

    localparam int WORD_WIDTH  = 32;
    localparam int INDEX_WIDTH = 8;
    localparam int KEY_COUNT   = 4;

    localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9E37_79B9;

    localparam logic [WORD_WIDTH-1:0] KEY_RESET_0 = 32'h5665_7824;
    localparam logic [WORD_WIDTH-1:0] KEY_RESET_1 = 32'h5674_5632;
    localparam logic [WORD_WIDTH-1:0] KEY_RESET_2 = 32'h9780_9879;
    localparam logic [WORD_WIDTH-1:0] KEY_RESET_3 = 32'h6576_7878;

    typedef enum logic [INDEX_WIDTH-1:0] {
        REG_KEY_ZERO  = 8'd0,
        REG_KEY_ONE   = 8'd1,
        REG_KEY_TWO   = 8'd2,
        REG_KEY_THREE = 8'd3
    } t_reg_index;

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef t_word t_key_set [KEY_COUNT];

    typedef struct packed {
        t_word v0;
        t_word v1;
    } t_block;

endpackage

FILE: hw/rtl/tvbd_ifs.sv
// Channel interfaces: cipher input, plain output and register writes.
// Depends on tvbd_pkg.
interface tvbd_cipher_if import tvbd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word cipher_first;
    t_word cipher_second;
    modport source (output valid, output cipher_first, output cipher_second, input ready);
    modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

interface tvbd_plain_if import tvbd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word plain_first;
    t_word plain_second;
    modport source (output valid, output plain_first, output plain_second, input ready);
    modport sink   (input valid, input plain_first, input plain_second, output ready);
endinterface

interface tvbd_cfg_if import tvbd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] index;
    t_word                  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/tvbd_key_regs.sv
// Key register file written through the configuration channel.
// Depends on tvbd_pkg and tvbd_cfg_if.
module tvbd_key_regs
    import tvbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tvbd_cfg_if.sink    i_cfg,
    output t_key_set    o_keys
);

    t_key_set r_keys;

    assign i_cfg.ready = 1'b1;
    assign o_keys      = r_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys[0] <= KEY_RESET_0;
            r_keys[1] <= KEY_RESET_1;
            r_keys[2] <= KEY_RESET_2;
            r_keys[3] <= KEY_RESET_3;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_KEY_ZERO:  r_keys[0] <= i_cfg.data;
                REG_KEY_ONE:   r_keys[1] <= i_cfg.data;
                REG_KEY_TWO:   r_keys[2] <= i_cfg.data;
                REG_KEY_THREE: r_keys[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/tvbd_half_round.sv
// One registered half round: updates v1 or v0 with a fixed sum.
// Depends on tvbd_pkg.
module tvbd_half_round
    import tvbd_pkg::*;
#(
    parameter logic [31:0] SUM       = 32'h0,
    parameter bit          UPDATE_V1 = 1'b1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_word  i_key,
    input  logic   i_valid,
    input  t_block i_data,
    output logic   o_ready,
    output logic   o_valid,
    output t_block o_data,
    input  logic   i_ready
);

    logic   r_valid;
    t_block r_data;
    t_block n_data;
    t_word  src;
    t_word  mix;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        src    = UPDATE_V1 ? i_data.v0 : i_data.v1;
        mix    = (src >> 5) ^ (src << 4);
        n_data = i_data;
        if (UPDATE_V1) begin
            n_data.v1 = i_data.v1 - (mix + i_key + (SUM ^ src));
        end else begin
            n_data.v0 = i_data.v0 - (mix + i_key + (SUM ^ src));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: hw/rtl/tea_variant_block_decipher_core.sv
// Block decipher core, one half round per pipeline stage.
// Throughput: one request per cycle; each stage holds while the next is full.
// Reset (synchronous, active low) empties the pipe and loads the default keys.
// Depends on tvbd_pkg, tvbd_ifs, tvbd_key_regs and tvbd_half_round.
module tea_variant_block_decipher_core
    import tvbd_pkg::*;
#(
    parameter int ROUND_COUNT = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tvbd_cipher_if.sink  i_cipher,
    tvbd_plain_if.source o_plain,
    tvbd_cfg_if.sink     i_cfg
);

    localparam int STAGE_COUNT = 2 * ROUND_COUNT;

    t_key_set keys;
    logic     valid [STAGE_COUNT+1];
    logic     ready [STAGE_COUNT+1];
    t_block   data  [STAGE_COUNT+1];

    tvbd_key_regs u_key_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_keys  (keys)
    );

    assign valid[0]       = i_cipher.valid;
    assign data[0].v0     = i_cipher.cipher_first;
    assign data[0].v1     = i_cipher.cipher_second;
    assign i_cipher.ready = ready[0];

    assign o_plain.valid        = valid[STAGE_COUNT];
    assign o_plain.plain_first  = data[STAGE_COUNT].v0;
    assign o_plain.plain_second = data[STAGE_COUNT].v1;
    assign ready[STAGE_COUNT]   = o_plain.ready;

    for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
        localparam logic [63:0] PROD_PRE  = 64'(ROUND_COUNT - r) * 64'(TEA_DELTA);
        localparam logic [63:0] PROD_POST = 64'(ROUND_COUNT - r - 1) * 64'(TEA_DELTA);
        localparam logic [31:0] SUM_PRE   = PROD_PRE[31:0];
        localparam logic [31:0] SUM_POST  = PROD_POST[31:0];
        localparam logic [1:0]  SEL_PRE   = SUM_PRE[12:11];
        localparam logic [1:0]  SEL_POST  = SUM_POST[1:0];

        tvbd_half_round #(
            .SUM       (SUM_PRE),
            .UPDATE_V1 (1'b1)
        ) u_v1_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (keys[SEL_PRE]),
            .i_valid (valid[2*r]),
            .i_data  (data[2*r]),
            .o_ready (ready[2*r]),
            .o_valid (valid[2*r+1]),
            .o_data  (data[2*r+1]),
            .i_ready (ready[2*r+1])
        );

        tvbd_half_round #(
            .SUM       (SUM_POST),
            .UPDATE_V1 (1'b0)
        ) u_v0_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (keys[SEL_POST]),
            .i_valid (valid[2*r+1]),
            .i_data  (data[2*r+1]),
            .o_ready (ready[2*r+1]),
            .o_valid (valid[2*r+2]),
            .o_data  (data[2*r+2]),
            .i_ready (ready[2*r+2])
        );
    end

endmodule
